### sv/hex_text_to_bytes_parser_top_macros.svh
// Assertion macros for the hex text to bytes parser
`ifndef HEX_TEXT_TO_BYTES_PARSER_TOP_MACROS_SVH
`define HEX_TEXT_TO_BYTES_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low
`define HTB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low
`define HTB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/htb_pkg.sv
// Package: types, constants and decode helpers of the hex text parser
`default_nettype none

package htb_pkg;

  localparam int unsigned CharW        = 8;
  localparam int unsigned LenW         = 13;
  localparam int unsigned NibW         = 4;
  localparam int unsigned MaxStringLen = 4096;

  localparam logic [LenW-1:0] CapReset = LenW'(32);
  localparam logic [LenW-1:0] PosMax   = '1;

  localparam logic [CharW-1:0] ChDash  = 8'h2D;
  localparam logic [CharW-1:0] ChColon = 8'h3A;
  localparam logic [CharW-1:0] ChUnder = 8'h5F;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChDot   = 8'h2E;
  localparam logic [CharW-1:0] Ch0     = 8'h30;
  localparam logic [CharW-1:0] Ch9     = 8'h39;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpF   = 8'h46;
  localparam logic [CharW-1:0] ChLoA   = 8'h61;
  localparam logic [CharW-1:0] ChLoF   = 8'h66;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StBadLen = 2'd1,
    StFull   = 2'd2,
    StBadHex = 2'd3
  } status_e;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic [LenW-1:0]  string_length;
    logic             last_char;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] byte_value;
    logic             byte_valid;
    logic             done_res;
    status_e          status;
    logic [LenW-1:0]  bytes_written;
  } res_t;

  typedef struct packed {
    logic            ok;
    logic [NibW-1:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [CharW-1:0] c);
    hex_t h;
    h = '0;
    if (c >= Ch0 && c <= Ch9) begin
      h.ok    = 1'b1;
      h.value = NibW'(c - Ch0);
    end else if (c >= ChUpA && c <= ChUpF) begin
      h.ok    = 1'b1;
      h.value = NibW'(c - ChUpA + 8'd10);
    end else if (c >= ChLoA && c <= ChLoF) begin
      h.ok    = 1'b1;
      h.value = NibW'(c - ChLoA + 8'd10);
    end
    return h;
  endfunction

  function automatic logic is_sep(input logic [CharW-1:0] c);
    return (c == ChDash) || (c == ChColon) || (c == ChUnder) ||
           (c == ChSpace) || (c == ChDot);
  endfunction

endpackage

`default_nettype wire

### sv/htb_if.sv
// Channel interfaces: input characters, result items, capacity writes
`default_nettype none

interface htb_in_if import htb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic [LenW-1:0]  string_length;
  logic             last_char;

  modport source (output valid, char_code, string_length, last_char, input ready);
  modport sink   (input valid, char_code, string_length, last_char, output ready);
endinterface

interface htb_out_if import htb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] byte_value;
  logic             byte_valid;
  logic             done_res;
  logic [1:0]       status;
  logic [LenW-1:0]  bytes_written;

  modport source (output valid, byte_value, byte_valid, done_res, status, bytes_written,
                  input ready);
  modport sink   (input valid, byte_value, byte_valid, done_res, status, bytes_written,
                  output ready);
endinterface

interface htb_cfg_if import htb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [LenW-1:0] output_capacity;

  modport source (output valid, output_capacity, input ready);
  modport sink   (input valid, output_capacity, output ready);
endinterface

`default_nettype wire

### sv/htb_in_stage.sv
// Input register: holds one accepted character item until the decoder takes it
`default_nettype none

module htb_in_stage import htb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  htb_in_if.sink        in_i,
  input  logic          advance_i,
  output logic          valid_o,
  output in_item_t      item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign in_i.ready = !valid_q || advance_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= '{char_code: in_i.char_code, string_length: in_i.string_length,
                  last_char: in_i.last_char};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

### sv/htb_decode.sv
// Decoder: per-string state, capacity register and the single-step decode logic
`default_nettype none

module htb_decode import htb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_data_i,
  input  logic            fire_i,
  input  in_item_t        item_i,
  output logic            res_valid_o,
  output res_t            res_o,
  output logic [LenW-1:0] cap_o
);

  logic [LenW-1:0] cap_q;
  logic [LenW-1:0] pos_q, pos_d;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic            pend_q, pend_d;
  logic [NibW-1:0] hnib_q, hnib_d;
  logic            drain_q, drain_d;

  hex_t            hx;
  logic            sep;
  logic            len_bad;
  logic            pair_start;
  logic [LenW+1:0] cap3;

  assign hx   = hex_digit(item_i.char_code);
  assign sep  = is_sep(item_i.char_code);
  assign cap3 = (LenW+2)'({cap_q, 1'b0}) + (LenW+2)'(cap_q);
  // capacity < len/3 + 1 is the same as 3*capacity <= len
  assign len_bad = (item_i.string_length < LenW'(2)) ||
                   ((LenW+2)'(item_i.string_length) > (LenW+2)'(MaxStringLen)) ||
                   (cap3 <= (LenW+2)'(item_i.string_length));
  assign pair_start = ((LenW+1)'(pos_q) + (LenW+1)'(1) <
                       (LenW+1)'(item_i.string_length)) && !sep;

  always_comb begin
    logic    fail;
    logic    clear;
    status_e fail_st;

    fail    = 1'b0;
    clear   = 1'b0;
    fail_st = StOk;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    hnib_d  = hnib_q;
    drain_d = drain_q;
    res_valid_o = 1'b0;
    res_o       = '{byte_value: '0, byte_valid: 1'b0, done_res: 1'b0,
                    status: StOk, bytes_written: cnt_q};

    if (fire_i) begin
      if (drain_q) begin
        clear = item_i.last_char;
      end else begin
        if (pos_q != PosMax) begin
          pos_d = pos_q + LenW'(1);
        end
        if (pos_q == '0 && len_bad) begin
          fail    = 1'b1;
          fail_st = StBadLen;
        end else if (pend_q) begin
          if (!hx.ok) begin
            fail    = 1'b1;
            fail_st = StBadHex;
          end else begin
            pend_d      = 1'b0;
            cnt_d       = cnt_q + LenW'(1);
            res_valid_o = 1'b1;
            res_o.byte_value    = {hnib_q, hx.value};
            res_o.byte_valid    = 1'b1;
            res_o.done_res      = item_i.last_char;
            res_o.bytes_written = cnt_d;
            clear = item_i.last_char;
          end
        end else begin
          if (pair_start) begin
            priority if (cnt_q >= cap_q) begin
              fail    = 1'b1;
              fail_st = StFull;
            end else if (!hx.ok || item_i.last_char) begin
              // bad first digit, or early end: a first digit on the last character cannot pair
              fail    = 1'b1;
              fail_st = StBadHex;
            end else begin
              pend_d = 1'b1;
              hnib_d = hx.value;
            end
          end
          if (!fail && item_i.last_char) begin
            res_valid_o    = 1'b1;
            res_o.done_res = 1'b1;
            clear          = 1'b1;
          end
        end
        if (fail) begin
          res_valid_o    = 1'b1;
          res_o.done_res = 1'b1;
          res_o.status   = fail_st;
          if (item_i.last_char) begin
            clear = 1'b1;
          end else begin
            drain_d = 1'b1;
          end
        end
      end
      if (clear) begin
        pos_d   = '0;
        cnt_d   = '0;
        pend_d  = 1'b0;
        hnib_d  = '0;
        drain_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CapReset;
      pos_q   <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      hnib_q  <= '0;
      drain_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      hnib_q  <= hnib_d;
      drain_q <= drain_d;
    end
  end

  assign cap_o = cap_q;

endmodule

`default_nettype wire

### sv/htb_out_reg.sv
// Result register: holds one result item until the receiver takes it
`default_nettype none

module htb_out_reg import htb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      res_valid_i,
  input  res_t      res_i,
  output logic      take_o,
  htb_out_if.source out_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign take_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (take_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.byte_value    = res_q.byte_value;
  assign out_o.byte_valid    = res_q.byte_valid;
  assign out_o.done_res      = res_q.done_res;
  assign out_o.status        = res_q.status;
  assign out_o.bytes_written = res_q.bytes_written;

endmodule

`default_nettype wire

### sv/hex_text_to_bytes_parser_top.sv
// Hex text to bytes parser: one character per item in, decoded bytes and status out
//
// Channels: in_i takes one character item (char_code, string_length, last_char);
// out_o gives result items (byte_value, byte_valid, done_res, status,
// bytes_written); cfg_i writes output_capacity, always ready; the user uses it only while idle;
// the block does not enforce this. An item moves on a channel at a rising edge with valid
// and ready both high. Each decoded hex pair gives one result; the last character of a
// string gives the final result (done_res) with the status and byte count. After an error
// the block reports once and drops characters up to the last one of the string.
// A result reaches out_o through the input register and then the result register: the
// accepting edge loads the input register, and the decoded result is loaded into the
// result register once that register can take it.
// Throughput: one character per cycle while out_o takes its results, set by the single
// decode step between the input register and the result register.
// Reset: clears all per-string state and loads output_capacity with 32.
// Stall: while out_o holds a result that is not taken, decode holds, the input
// register keeps its character, and in_i takes at most one more item into an
// empty input register, then drops ready.
`default_nettype none

`include "hex_text_to_bytes_parser_top_macros.svh"

module hex_text_to_bytes_parser_top import htb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  htb_cfg_if.sink   cfg_i,
  htb_in_if.sink    in_i,
  htb_out_if.source out_o
);

  logic            s1_valid;
  in_item_t        s1_item;
  logic            out_take;
  logic            fire;
  logic            res_valid;
  res_t            res;
  logic [LenW-1:0] cap;
  logic            err_res;
  logic            byte_res;

  // Capacity writes are taken at once
  assign cfg_i.ready = 1'b1;

  // Decode the held character whenever the result register can take its result
  assign fire = s1_valid && out_take;

  htb_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (out_take),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  htb_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.output_capacity),
    .fire_i      (fire),
    .item_i      (s1_item),
    .res_valid_o (res_valid),
    .res_o       (res),
    .cap_o       (cap)
  );

  htb_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .take_o      (out_take),
    .out_o       (out_o)
  );

  assign err_res  = out_o.valid && (out_o.status != StOk);
  assign byte_res = out_o.valid && out_o.byte_valid;

  // Error results carry no byte and always end the string
  `HTB_ASSERT_IMP(a_err_final, err_res, !out_o.byte_valid && out_o.done_res, "error not final")

  // A decoded byte never pushes the count past the capacity
  `HTB_ASSERT_IMP(a_byte_cap, byte_res, out_o.bytes_written <= cap, "byte count over capacity")

  // Hold the input register while the result register is blocked
  `HTB_ASSERT_NXT(a_hold_input, s1_valid && !out_take, s1_valid, "input item lost under stall")

endmodule

`default_nettype wire

### bench/tb_hex_text_to_bytes_parser_top.sv
// Testbench of the hex text to bytes parser: directed and random strings, checked per result
module tb_hex_text_to_bytes_parser_top;
  import htb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let the two-stage pipeline settle once no result is pending
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned MaxGap       = 17;

  logic clk_i;
  logic rst_ni;

  htb_in_if  in_if ();
  htb_out_if out_if ();
  htb_cfg_if cfg_if ();

  hex_text_to_bytes_parser_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow of the parser: capacity register and per-string state
  logic [LenW-1:0] cap_q;
  logic [LenW-1:0] pos_q;
  logic [LenW-1:0] nbytes_q;
  logic            nib_pend_q;
  logic [3:0]      hi_q;
  logic            drain_q;

  // Results the parser owes us, oldest first
  res_t decoded_q[$];

  // Run bookkeeping
  int unsigned n_errors;
  int unsigned n_chars;
  int unsigned n_strings;
  int unsigned n_results;
  int unsigned n_cfg_writes;

  // Idling knobs of the sender (tx_gaps) and the receiver (rx_gaps, rx_hold_cycles)
  bit          tx_gaps;
  bit          rx_gaps;
  int unsigned rx_hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Parser prediction
  // ------------------------------------------------------------------------

  function automatic bit hex_value(input logic [7:0] c, output logic [3:0] v);
    v = '0;
    if (c >= Ch0 && c <= Ch9) begin
      v = 4'(c - Ch0);
      return 1'b1;
    end
    if (c >= ChUpA && c <= ChUpF) begin
      v = 4'(c - ChUpA + 8'd10);
      return 1'b1;
    end
    if (c >= ChLoA && c <= ChLoF) begin
      v = 4'(c - ChLoA + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit is_skip_char(input logic [7:0] c);
    return c == ChDash || c == ChColon || c == ChUnder || c == ChSpace || c == ChDot;
  endfunction

  function automatic void restart_string();
    pos_q      = '0;
    nbytes_q   = '0;
    nib_pend_q = 1'b0;
    hi_q       = '0;
    drain_q    = 1'b0;
  endfunction

  // An error reports once; off the last character the parser then drops input
  function automatic bit report_error(input status_e st, input logic last, output res_t r);
    r               = '0;
    r.done_res      = 1'b1;
    r.status        = st;
    r.bytes_written = nbytes_q;
    if (last) restart_string();
    else drain_q = 1'b1;
    return 1'b1;
  endfunction

  // Advance the shadow by one accepted character; return 1 when it yields a result
  function automatic bit decode_char(input in_item_t it, output res_t r);
    logic [LenW-1:0] p;
    logic [3:0]      nib;
    bit              is_hex;
    r = '0;
    if (drain_q) begin
      if (it.last_char) restart_string();
      return 1'b0;
    end
    p = pos_q;
    if (pos_q != PosMax) pos_q = pos_q + 1'b1;
    if (p == 0 && (it.string_length < 2 || it.string_length > MaxStringLen ||
                   int'(cap_q) < int'(it.string_length) / 3 + 1)) begin
      return report_error(StBadLen, it.last_char, r);
    end
    is_hex = hex_value(it.char_code, nib);
    if (nib_pend_q) begin
      if (!is_hex) return report_error(StBadHex, it.last_char, r);
      nib_pend_q      = 1'b0;
      nbytes_q        = nbytes_q + 1'b1;
      r.byte_value    = {hi_q, nib};
      r.byte_valid    = 1'b1;
      r.done_res      = it.last_char;
      r.status        = StOk;
      r.bytes_written = nbytes_q;
      if (it.last_char) restart_string();
      return 1'b1;
    end
    if (int'(p) + 1 < int'(it.string_length) && !is_skip_char(it.char_code)) begin
      if (nbytes_q >= cap_q) return report_error(StFull, it.last_char, r);
      if (!is_hex || it.last_char) return report_error(StBadHex, it.last_char, r);
      nib_pend_q = 1'b1;
      hi_q       = nib;
    end
    if (it.last_char) begin
      r.done_res      = 1'b1;
      r.status        = StOk;
      r.bytes_written = nbytes_q;
      restart_string();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ------------------------------------------------------------------------
  // Sender side
  // ------------------------------------------------------------------------

  // Offer one character; return at the edge that accepts it
  task automatic send_char(input logic [7:0] c, input logic [LenW-1:0] len, input bit last);
    int unsigned gap;
    in_item_t    it;
    res_t        r;
    gap = tx_gaps ? $urandom_range(0, MaxGap) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.char_code     <= c;
    in_if.string_length <= len;
    in_if.last_char     <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    it.char_code     = c;
    it.string_length = len;
    it.last_char     = last;
    if (decode_char(it, r)) decoded_q.push_back(r);
    n_chars++;
  endtask

  // Send a whole string; last_char marks its final character
  task automatic send_text(ref logic [7:0] q[$], input logic [LenW-1:0] len);
    int unsigned i;
    for (i = 0; i < q.size(); i++) send_char(q[i], len, i == q.size() - 1);
    n_strings++;
  endtask

  task automatic send_str(input string s, input logic [LenW-1:0] len);
    logic [7:0]  q[$];
    int unsigned i;
    for (i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_text(q, len);
  endtask

  // Drop valid and hold until every owed result has come and the pipe is empty
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [LenW-1:0] cap);
    wait_drained();
    cfg_if.valid           <= 1'b1;
    cfg_if.output_capacity <= cap;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    cap_q = cap;
    n_cfg_writes++;
  endtask

  // ------------------------------------------------------------------------
  // Text generation
  // ------------------------------------------------------------------------

  function automatic logic [7:0] pick_hex_char();
    int unsigned v;
    v = $urandom_range(0, 15);
    if (v < 10) return Ch0 + 8'(v);
    return ($urandom_range(0, 1) != 0) ? ChUpA + 8'(v - 10) : ChLoA + 8'(v - 10);
  endfunction

  function automatic logic [7:0] pick_skip_char();
    case ($urandom_range(0, 4))
      0: return ChDash;
      1: return ChColon;
      2: return ChUnder;
      3: return ChSpace;
      default: return ChDot;
    endcase
  endfunction

  // Well-formed text: digit pairs, separators only in front of a pair
  function automatic void make_text(ref logic [7:0] q[$], input int unsigned pairs);
    int unsigned i;
    q.delete();
    for (i = 0; i < pairs; i++) begin
      if ($urandom_range(0, 3) == 0) q.push_back(pick_skip_char());
      q.push_back(pick_hex_char());
      q.push_back(pick_hex_char());
    end
    // A trailing character on the last position is never a pair start
    if ($urandom_range(0, 3) == 0) begin
      q.push_back(($urandom_range(0, 1) != 0) ? pick_skip_char() : pick_hex_char());
    end
  endfunction

  task automatic send_random_string();
    logic [7:0]      q[$];
    logic [LenW-1:0] len;
    int unsigned     pairs;
    int unsigned     k;
    pairs = $urandom_range(1, (cap_q < 12) ? int'(cap_q) + 2 : 14);
    if ($urandom_range(0, 9) == 0) pairs = $urandom_range(1, 40);
    make_text(q, pairs);
    len = LenW'(q.size());
    case ($urandom_range(0, 9))
      6: begin
        // corrupt one character
        k    = $urandom_range(0, q.size() - 1);
        q[k] = 8'($urandom_range(0, 255));
      end
      7: len = LenW'($urandom_range(0, 8191));
      8: begin
        // end early: the length field still claims the full string
        if (q.size() > 1) void'(q.pop_back());
      end
      9: begin
        // raw noise
        q.delete();
        repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
        len = LenW'(q.size());
      end
      default: ;
    endcase
    tx_gaps = $urandom_range(0, 4) != 0;
    rx_gaps = $urandom_range(0, 4) != 0;
    send_text(q, len);
  endtask

  // ------------------------------------------------------------------------
  // Receiver side: stall at random, check every result against the oldest one owed
  // ------------------------------------------------------------------------

  task automatic check_result();
    res_t want;
    n_results++;
    if (decoded_q.size() == 0) begin
      $error("unexpected result: byte_value %0h done_res %0d status %0d",
             out_if.byte_value, out_if.done_res, out_if.status);
      n_errors++;
      return;
    end
    want = decoded_q.pop_front();
    if (out_if.byte_value !== want.byte_value) begin
      $error("byte_value: expected %0h, got %0h", want.byte_value, out_if.byte_value);
      n_errors++;
    end
    if (out_if.byte_valid !== want.byte_valid) begin
      $error("byte_valid: expected %0d, got %0d", want.byte_valid, out_if.byte_valid);
      n_errors++;
    end
    if (out_if.done_res !== want.done_res) begin
      $error("done_res: expected %0d, got %0d", want.done_res, out_if.done_res);
      n_errors++;
    end
    if (out_if.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, out_if.status);
      n_errors++;
    end
    if (out_if.bytes_written !== want.bytes_written) begin
      $error("bytes_written: expected %0d, got %0d", want.bytes_written, out_if.bytes_written);
      n_errors++;
    end
  endtask

  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      int unsigned stall;
      // Long hold-off requested by the pressure test, counted here
      if (rx_hold_cycles != 0) begin
        out_if.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end
      stall = rx_gaps ? $urandom_range(0, MaxGap) : 0;
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      check_result();
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Clean strings: closing pair on the last character, trailing ignored character
  task automatic test_good_strings();
    logic [7:0] q[$];
    send_str("fF:00", 5);
    send_str("0aF9", 4);
    send_str("12.3", 4);
    // NUL on the last position is ignored and gives a quiet end
    q = '{"4", "F", 8'h00};
    send_text(q, 3);
  endtask

  // Length and hex errors, each reported once, then everything dropped up to last_char
  task automatic test_errors();
    logic [7:0] q[$];
    send_str("1g", 2);         // bad second digit on the last character
    q = '{8'hFF, "1", "2", 8'h00};
    send_text(q, 4);           // bad first digit, rest drained
    send_str("1 2", 3);        // separator inside a pair
    send_str("AB5", 4);        // last_char with a new first digit: early end
    send_str("7", 0);          // length field extremes
    send_str("5", 1);
    send_str("ab", 4097);
    send_str("0", 8191);
    send_str("00", MaxStringLen); // too long for the reset capacity
  endtask

  // Capacity limits: full output, smallest usable capacity, zero capacity
  task automatic test_capacity();
    write_capacity(3);
    send_str("a1b2c3d4", 8);
    write_capacity(1);
    send_str("9C", 2);
    write_capacity(0);
    send_str("00", 2);
  endtask

  // Random strings over a range of capacities, extremes included
  task automatic test_random(input int unsigned goal);
    logic [LenW-1:0] caps[8];
    int unsigned     k;
    int unsigned     start;
    caps = '{CapReset, LenW'(4), LenW'(0), LenW'(2), LenW'(8191), LenW'(1), LenW'(4096),
             LenW'(0)};
    caps[7] = LenW'($urandom_range(3, 40));
    for (k = 0; k < 8; k++) begin
      write_capacity(caps[k]);
      start = n_chars;
      while (n_chars - start < goal / 8) send_random_string();
    end
  endtask

  // Stall the result side long enough to back up the input, then let it all drain
  task automatic test_backpressure();
    logic [7:0] q[$];
    write_capacity(4096);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    rx_hold_cycles = 60;
    make_text(q, 20);
    send_text(q, LenW'(q.size()));
    // pause the sender until nothing is owed
    wait_drained();
    rx_gaps = 1'b1;
    rx_hold_cycles = 45;
    make_text(q, 12);
    send_text(q, LenW'(q.size()));
    wait_drained();
  endtask

  // Longest legal length field, then characters past the last position of a string
  task automatic test_long_string();
    logic [7:0]  q[$];
    int unsigned p;
    write_capacity(4096);
    tx_gaps = 1'b0;
    rx_gaps = 1'b1;
    // the length field claims the longest legal string; only a few characters come
    q = '{"5", "a", ":", "3", "e"};
    send_text(q, LenW'(MaxStringLen));
    // pair on the last two positions; the second digit sits on the last one
    q = '{"1", "2"};
    for (p = 2; p < 22; p++) q.push_back(pick_skip_char());
    q.push_back("3");
    q.push_back("e");
    // past the end: never a pair start
    for (p = 0; p < 24; p++) q.push_back(pick_hex_char());
    send_text(q, 24);
    wait_drained();
  endtask

  initial begin
    in_if.valid            <= 1'b0;
    in_if.char_code        <= '0;
    in_if.string_length    <= '0;
    in_if.last_char        <= 1'b0;
    cfg_if.valid           <= 1'b0;
    cfg_if.output_capacity <= '0;
    rst_ni                 <= 1'b0;
    n_errors       = 0;
    n_chars        = 0;
    n_strings      = 0;
    n_results      = 0;
    n_cfg_writes   = 0;
    tx_gaps        = 1'b1;
    rx_gaps        = 1'b1;
    rx_hold_cycles = 0;
    cap_q          = CapReset;
    restart_string();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_good_strings();
    test_errors();
    test_capacity();
    test_random(160);
    test_backpressure();
    test_long_string();

    wait_drained();
    $display("Run covered %0d strings, %0d characters and %0d results,", n_strings, n_chars,
             n_results);
    $display("with %0d capacity writes, back-pressure and characters past a string's end.",
             n_cfg_writes);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
